/* design/graph_degree_counter_top_assert.svh */
// Assertion macros shared by the graph degree counter modules.
`ifndef GRAPH_DEGREE_COUNTER_TOP_ASSERT_SVH
`define GRAPH_DEGREE_COUNTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define GDC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdc: assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define GDC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdc: assertion failed");

`endif

/* design/gdc_pkg.sv */
// Shared constants, codes and types of the graph degree counter.
package gdc_pkg;

    localparam int VTX_W            = 5;
    localparam int ENTRY_W          = 8;
    localparam int DEG_W            = 13;
    localparam int KIND_W           = 2;
    localparam int CFG_W            = 6;
    localparam int MAX_VERTICES_DEF = 32;
    localparam int QUEUE_DEPTH_DEF  = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_UNDIR = 2'd0,
        KIND_OUT   = 2'd1,
        KIND_IN    = 2'd2
    } degree_kind_t;

    // One classified matrix entry, front to back.
    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic [VTX_W-1:0]   row;
        logic [VTX_W-1:0]   col;
        logic               first;
        logic               row_first;
        logic               col_first;
        logic               row_end;
        logic               mirror_chk;
        logic               last;
    } entry_op_t;

endpackage

/* design/gdc_ifs.sv */
// Valid/ready channel interfaces of the graph degree counter.
interface gdc_entry_if import gdc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ENTRY_W-1:0] entry_value;

    modport source (output valid, output entry_value, input ready);
    modport sink   (input valid, input entry_value, output ready);
endinterface

interface gdc_cfg_if import gdc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] vertex_count;

    modport source (output valid, output vertex_count, input ready);
    modport sink   (input valid, input vertex_count, output ready);
endinterface

interface gdc_degree_if import gdc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] degree_kind;
    logic [VTX_W-1:0]  vertex_index;
    logic [DEG_W-1:0]  degree_value;
    logic              last_result;

    modport source (output valid, output degree_kind, output vertex_index,
                    output degree_value, output last_result, input ready);
    modport sink   (input valid, input degree_kind, input vertex_index,
                    input degree_value, input last_result, output ready);
endinterface

/* design/graph_degree_counter_top.sv */
// Top level of the graph degree counter: front, entry queue and back end.
// Matrix entries (row-major, n = vertex_count) are taken one per cycle
// while the queue has room; the front tags each with its position and the
// back end updates the matrix store and the row and column sums as it takes
// an entry, the mirror compare settling the symmetry flag in the cycle
// after, so a matrix of n*n entries streams at one entry per cycle while
// nothing stalls. After the last entry the back end waits in S_WAIT, then
// in S_EMIT gives n undirected degrees (symmetric matrix) or n out-degrees
// followed by n in-degrees, one result per cycle while the sink takes
// them; meanwhile up to QUEUE_DEPTH entries of the next matrix are taken
// into the queue. The matrix memory, one write and one registered read per
// cycle, needs no clearing pass. A vertex_count write restarts the matrix.
module graph_degree_counter_top import gdc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    gdc_entry_if.sink    entries,
    gdc_cfg_if.sink      cfg,
    gdc_degree_if.source degrees
);

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);

    entry_op_t        front_op;
    logic             front_valid;
    logic             front_ready;
    entry_op_t        back_op;
    logic             back_valid;
    logic             back_ready;
    logic [CNT_W-1:0] vertex_count;

    gdc_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .entries      (entries),
        .cfg          (cfg),
        .op           (front_op),
        .op_valid     (front_valid),
        .op_ready     (front_ready),
        .vertex_count (vertex_count)
    );

    gdc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_op    (front_op),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_op     (back_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    gdc_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (back_op),
        .op_valid     (back_valid),
        .op_ready     (back_ready),
        .vertex_count (vertex_count),
        .degrees      (degrees)
    );

endmodule

/* design/gdc_front.sv */
// Front end: vertex count register, matrix position tracking, entry classification.
module gdc_front import gdc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    gdc_entry_if.sink         entries,
    gdc_cfg_if.sink           cfg,
    output entry_op_t         op,
    output logic              op_valid,
    input  logic              op_ready,
    output logic [CNT_W-1:0]  vertex_count
);

    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] n_next;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] row_next;
    logic [IDX_W-1:0] col_reg;
    logic [IDX_W-1:0] col_next;
    logic [CFG_W-1:0] cfg_sat;
    logic             accept;
    logic             row_end;
    logic             row_last;

    assign cfg.ready     = 1'b1;
    assign entries.ready = op_ready;
    assign op_valid      = entries.valid;
    assign accept        = entries.valid && op_ready;
    assign vertex_count  = n_reg;

    assign row_end  = (CNT_W'(col_reg) + CNT_W'(1)) == n_reg;
    assign row_last = (CNT_W'(row_reg) + CNT_W'(1)) == n_reg;

    always_comb
    begin
        op.value      = entries.entry_value;
        op.row        = VTX_W'(row_reg);
        op.col        = VTX_W'(col_reg);
        op.first      = (row_reg == '0) && (col_reg == '0);
        op.row_first  = (row_reg == '0);
        op.col_first  = (col_reg == '0);
        op.row_end    = row_end;
        op.mirror_chk = col_reg < row_reg;
        op.last       = row_end && row_last;
    end

    always_comb
    begin
        if (cfg.vertex_count == '0)
            cfg_sat = CFG_W'(1);
        else if (cfg.vertex_count > CFG_W'(MAX_VERTICES))
            cfg_sat = CFG_W'(MAX_VERTICES);
        else
            cfg_sat = cfg.vertex_count;
    end

    always_comb
    begin
        n_next   = n_reg;
        row_next = row_reg;
        col_next = col_reg;
        if (cfg.valid)
        begin
            // new vertex count abandons any matrix in progress
            n_next   = CNT_W'(cfg_sat);
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = row_last ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= CNT_W'(MAX_VERTICES);
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            n_reg   <= n_next;
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

/* design/gdc_queue.sv */
// Short FIFO of classified entries between front and back.
module gdc_queue import gdc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_op_t push_op,
    input  logic      push_valid,
    output logic      push_ready,
    output entry_op_t pop_op,
    output logic      pop_valid,
    input  logic      pop_ready
);

`include "graph_degree_counter_top_assert.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_op_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push;
    logic             pop;

    assign push_ready = cnt_reg != CNT_W'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_op     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (pop && !push)
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    `GDC_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `GDC_ASSERT_NXT(a_cnt_grow, push && !pop, cnt_reg == $past(cnt_reg) + CNT_W'(1))
    `GDC_ASSERT_NXT(a_cnt_shrink, pop && !push, cnt_reg == $past(cnt_reg) - CNT_W'(1))

endmodule

/* design/gdc_back.sv */
// Back end: matrix store, row and column sums, symmetry check, degree emission.
module gdc_back import gdc_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    localparam int IDX_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
    localparam int CNT_W = $clog2(MAX_VERTICES + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  entry_op_t        op,
    input  logic             op_valid,
    output logic             op_ready,
    input  logic [CNT_W-1:0] vertex_count,
    gdc_degree_if.source     degrees
);

`include "graph_degree_counter_top_assert.svh"

    localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
    localparam int ADDR_W    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;

    typedef enum logic [1:0] {
        S_RUN,
        S_WAIT,
        S_EMIT
    } state_t;

    logic [ENTRY_W-1:0] mat_mem [MAT_DEPTH];
    logic [DEG_W-1:0]   row_sum_reg [MAX_VERTICES];
    logic [DEG_W-1:0]   col_sum_reg [MAX_VERTICES];

    state_t             state_reg;
    state_t             state_next;
    logic [IDX_W-1:0]   emit_idx_reg;
    logic [IDX_W-1:0]   emit_idx_next;
    logic               phase_reg;
    logic               phase_next;
    logic               sym_reg;
    logic               sym_next;
    logic               cmp_pend_reg;
    logic [ENTRY_W-1:0] cmp_val_reg;
    logic [ENTRY_W-1:0] mir_data_reg;
    logic [DEG_W-1:0]   row_acc_reg;

    logic               out_valid_reg;
    logic               out_valid_next;
    degree_kind_t       out_kind_reg;
    degree_kind_t       out_kind_next;
    logic [IDX_W-1:0]   out_idx_reg;
    logic [IDX_W-1:0]   out_idx_next;
    logic [DEG_W-1:0]   out_deg_reg;
    logic [DEG_W-1:0]   out_deg_next;
    logic               out_last_reg;
    logic               out_last_next;

    logic               pop;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   c_idx;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  mir_addr;
    logic [IDX_W-1:0]   col_rd_idx;
    logic [DEG_W-1:0]   col_rd;
    logic [DEG_W-1:0]   row_new;
    logic [DEG_W-1:0]   col_new;
    logic               load;
    logic               idx_last;
    logic               done_all;

    assign op_ready = state_reg == S_RUN;
    assign pop      = op_valid && op_ready;
    assign r_idx    = op.row[IDX_W-1:0];
    assign c_idx    = op.col[IDX_W-1:0];
    assign wr_addr  = ADDR_W'(int'(r_idx) * MAX_VERTICES + int'(c_idx));
    assign mir_addr = ADDR_W'(int'(c_idx) * MAX_VERTICES + int'(r_idx));

    assign col_rd_idx = (state_reg == S_EMIT) ? emit_idx_reg : c_idx;
    assign col_rd     = col_sum_reg[col_rd_idx];
    assign row_new    = (op.col_first ? '0 : row_acc_reg) + DEG_W'(op.value);
    assign col_new    = (op.row_first ? '0 : col_rd) + DEG_W'(op.value);

    assign load     = !out_valid_reg || degrees.ready;
    assign idx_last = (CNT_W'(emit_idx_reg) + CNT_W'(1)) == vertex_count;
    assign done_all = sym_reg || phase_reg;

    assign degrees.valid        = out_valid_reg;
    assign degrees.degree_kind  = out_kind_reg;
    assign degrees.vertex_index = VTX_W'(out_idx_reg);
    assign degrees.degree_value = out_deg_reg;
    assign degrees.last_result  = out_last_reg;

    // matrix store and sums; first row / first column overwrite instead of clearing
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            mat_mem[wr_addr]   <= op.value;
            mir_data_reg       <= mat_mem[mir_addr];
            cmp_val_reg        <= op.value;
            row_acc_reg        <= row_new;
            col_sum_reg[c_idx] <= col_new;
            if (op.row_end)
                row_sum_reg[r_idx] <= row_new;
        end
    end

    always_comb
    begin
        sym_next = sym_reg;
        if (pop && op.first)
            sym_next = 1'b1;
        else if (cmp_pend_reg && (mir_data_reg != cmp_val_reg))
            sym_next = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        emit_idx_next  = emit_idx_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !degrees.ready;
        out_kind_next  = out_kind_reg;
        out_idx_next   = out_idx_reg;
        out_deg_next   = out_deg_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            S_RUN:
            begin
                if (pop && op.last)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // last mirror compare settles here
                state_next    = S_EMIT;
                emit_idx_next = '0;
                phase_next    = 1'b0;
            end
            S_EMIT:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = emit_idx_reg;
                    out_last_next  = idx_last && done_all;
                    if (sym_reg)
                        out_kind_next = KIND_UNDIR;
                    else if (phase_reg)
                        out_kind_next = KIND_IN;
                    else
                        out_kind_next = KIND_OUT;
                    out_deg_next = phase_reg ? col_rd : row_sum_reg[emit_idx_reg];
                    if (idx_last)
                    begin
                        emit_idx_next = '0;
                        if (done_all)
                        begin
                            phase_next = 1'b0;
                            state_next = S_RUN;
                        end
                        else
                        begin
                            phase_next = 1'b1;
                        end
                    end
                    else
                    begin
                        emit_idx_next = emit_idx_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            emit_idx_reg  <= '0;
            phase_reg     <= 1'b0;
            sym_reg       <= 1'b1;
            cmp_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= KIND_UNDIR;
            out_idx_reg   <= '0;
            out_deg_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            emit_idx_reg  <= emit_idx_next;
            phase_reg     <= phase_next;
            sym_reg       <= sym_next;
            cmp_pend_reg  <= pop && op.mirror_chk;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_idx_reg   <= out_idx_next;
            out_deg_reg   <= out_deg_next;
            out_last_reg  <= out_last_next;
        end
    end

    `GDC_ASSERT_IMP(a_emit_idx_range, state_reg == S_EMIT, CNT_W'(emit_idx_reg) < vertex_count)
    `GDC_ASSERT_IMP(a_last_at_end, out_valid_reg && out_last_reg,
        (CNT_W'(out_idx_reg) + CNT_W'(1)) == vertex_count)
    `GDC_ASSERT_NXT(a_wait_after_last, pop && op.last, state_reg == S_WAIT)
    `GDC_ASSERT_IMP(a_no_cmp_in_emit, state_reg == S_EMIT, !cmp_pend_reg)

endmodule
